@@ design/gcr62_pkg.sv @@
// ----------------------------------------------------------------------------
// gcr62_pkg
// Shared types, constants, the code lookup function and a bit-swap helper for the 6-and-2 sector decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gcr62_pkg;

    localparam int POS_W        = 9;
    localparam int GROUP_ADDR_W = 7;
    localparam int GROUP_COUNT  = 86;

    localparam logic [POS_W-1:0] POS_IDLE        = 9'd370;
    localparam logic [POS_W-1:0] HDR_FIRST       = 9'd10;
    localparam logic [POS_W-1:0] HDR_LAST        = 9'd17;
    localparam logic [POS_W-1:0] POS_VOLUME      = 9'd11;
    localparam logic [POS_W-1:0] POS_TRACK       = 9'd13;
    localparam logic [POS_W-1:0] POS_SECTOR      = 9'd15;
    localparam logic [POS_W-1:0] DATA_FIRST      = 9'd28;
    localparam logic [POS_W-1:0] DATA_BYTE_FIRST = 9'd114;
    localparam logic [POS_W-1:0] GROUP_SPAN      = 9'd86;
    localparam logic [POS_W-1:0] GROUP_SPAN2     = 9'd172;
    localparam logic [7:0]       MARK_MASK       = 8'hAA;
    localparam logic [7:0]       VALUE_MASK      = 8'h55;
    localparam logic [7:0]       LAST_INDEX      = 8'hFF;

    typedef enum logic [1:0] {
        STATUS_DATA       = 2'd0,
        STATUS_BAD_PAIR   = 2'd1,
        STATUS_BAD_SUM    = 2'd2,
        STATUS_BAD_NIBBLE = 2'd3
    } status_t;

    // one result on its way from the front end to the output register
    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [5:0] upper;
        logic [7:0] index;
        logic [1:0] grp;
        logic [7:0] volume;
        logic [7:0] track;
        logic [7:0] sector;
        logic       done;
    } item_t;

    localparam logic [7:0] GCR6_CODES [64] = '{
        8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
        8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
        8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
        8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
        8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
        8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
        8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
        8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
    };

    // returns {valid, value}
    function automatic logic [6:0] code_lookup(input logic [7:0] code);
        logic [6:0] res;
        res = 7'd0;
        for (int k = 0; k < 64; k++)
        begin
            if (GCR6_CODES[k] == code)
            begin
                res = {1'b1, 6'(k)};
            end
        end
        return res;
    endfunction

    function automatic logic [1:0] swap2(input logic [1:0] v);
        return {v[0], v[1]};
    endfunction

endpackage

`default_nettype wire

@@ design/gcr62_group_ram.sv @@
// ----------------------------------------------------------------------------
// gcr62_group_ram
// Storage for the 86 chained values that carry the low bit groups.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr62_group_ram
    import gcr62_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    wr_en,
    input  wire logic [GROUP_ADDR_W-1:0] wr_addr,
    input  wire logic [5:0]              wr_data,
    input  wire logic                    rd_en,
    input  wire logic [GROUP_ADDR_W-1:0] rd_addr,
    output logic      [5:0]              rd_data
);

    logic [5:0] mem [GROUP_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ design/gcr62_front.sv @@
// ----------------------------------------------------------------------------
// gcr62_front
// Position tracking, header pair decode, nibble lookup and the XOR chain.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr62_front
    import gcr62_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic                    advance,
    input  wire logic [7:0]              disk_byte,
    input  wire logic                    sector_start,
    output logic                         wr_en,
    output logic      [GROUP_ADDR_W-1:0] wr_addr,
    output logic      [5:0]              wr_data,
    output logic                         rd_en,
    output logic      [GROUP_ADDR_W-1:0] rd_addr,
    output item_t                        item
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [5:0]       chain_reg, chain_next;
    logic [7:0]       pair_first_reg, pair_first_next;
    logic [7:0]       volume_reg, volume_next;
    logic [7:0]       track_reg, track_next;
    logic [7:0]       sector_reg, sector_next;
    logic             halted_reg, halted_next;
    item_t            item_reg, item_next;

    logic [POS_W-1:0] pos_eff, rel, jpos;
    logic [5:0]       chain_eff;
    logic [7:0]       pair_eff, vol_eff, trk_eff, sec_eff, pair_value;
    logic             halted_eff, active, in_hdr, in_data, pair_bad;
    logic [6:0]       lookup;
    logic [5:0]       nv;

    always_comb
    begin
        pos_eff    = sector_start ? '0 : pos_reg;
        chain_eff  = sector_start ? '0 : chain_reg;
        pair_eff   = sector_start ? '0 : pair_first_reg;
        vol_eff    = sector_start ? '0 : volume_reg;
        trk_eff    = sector_start ? '0 : track_reg;
        sec_eff    = sector_start ? '0 : sector_reg;
        halted_eff = sector_start ? 1'b0 : halted_reg;

        active  = !halted_eff && (pos_eff < POS_IDLE);
        in_hdr  = (pos_eff >= HDR_FIRST) && (pos_eff <= HDR_LAST);
        in_data = (pos_eff >= DATA_FIRST) && (pos_eff < POS_IDLE);
        rel     = pos_eff - DATA_FIRST;
        jpos    = pos_eff - DATA_BYTE_FIRST;

        pair_bad   = ((pair_eff & MARK_MASK) != MARK_MASK) ||
                     ((disk_byte & MARK_MASK) != MARK_MASK);
        pair_value = ((pair_eff & VALUE_MASK) << 1) | (disk_byte & VALUE_MASK);

        lookup = code_lookup(disk_byte);
        nv     = lookup[5:0] ^ chain_eff;

        pos_next        = pos_eff;
        chain_next      = chain_eff;
        pair_first_next = pair_eff;
        volume_next     = vol_eff;
        track_next      = trk_eff;
        sector_next     = sec_eff;
        halted_next     = halted_eff;

        wr_en   = 1'b0;
        wr_addr = rel[GROUP_ADDR_W-1:0];
        wr_data = nv;
        rd_en   = 1'b0;
        rd_addr = jpos[GROUP_ADDR_W-1:0];

        item_next        = item_reg;
        item_next.valid  = 1'b0;
        item_next.status = STATUS_DATA;
        item_next.upper  = nv;
        item_next.index  = jpos[7:0];
        item_next.grp    = 2'd0;
        item_next.volume = vol_eff;
        item_next.track  = trk_eff;
        item_next.sector = sec_eff;
        item_next.done   = (jpos[7:0] == LAST_INDEX);

        // which slot and which 2-bit group a data byte takes
        if (jpos >= GROUP_SPAN2)
        begin
            rd_addr       = 7'(jpos - GROUP_SPAN2);
            item_next.grp = 2'd2;
        end
        else if (jpos >= GROUP_SPAN)
        begin
            rd_addr       = 7'(jpos - GROUP_SPAN);
            item_next.grp = 2'd1;
        end

        if (active)
        begin
            pos_next = pos_eff + 9'd1;
            if (in_hdr)
            begin
                if (!pos_eff[0])
                begin
                    pair_first_next = disk_byte;
                end
                else if (pair_bad)
                begin
                    item_next.valid  = 1'b1;
                    item_next.status = STATUS_BAD_PAIR;
                end
                else if (pos_eff == POS_VOLUME)
                begin
                    volume_next = pair_value;
                end
                else if (pos_eff == POS_TRACK)
                begin
                    track_next = pair_value;
                end
                else if (pos_eff == POS_SECTOR)
                begin
                    sector_next = pair_value;
                end
                else if (pair_value != (vol_eff ^ trk_eff ^ sec_eff))
                begin
                    item_next.valid  = 1'b1;
                    item_next.status = STATUS_BAD_SUM;
                end
            end
            else if (in_data)
            begin
                if (!lookup[6])
                begin
                    item_next.valid  = 1'b1;
                    item_next.status = STATUS_BAD_NIBBLE;
                end
                else
                begin
                    chain_next = nv;
                    if (pos_eff < DATA_BYTE_FIRST)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        rd_en           = 1'b1;
                        item_next.valid = 1'b1;
                    end
                end
            end
        end

        // error words carry zero data and index and close the sector
        if (item_next.valid && (item_next.status != STATUS_DATA))
        begin
            halted_next     = 1'b1;
            item_next.upper = 6'd0;
            item_next.index = 8'd0;
            item_next.done  = 1'b1;
        end

        if (!accept)
        begin
            wr_en = 1'b0;
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= POS_IDLE;
            chain_reg      <= '0;
            pair_first_reg <= '0;
            volume_reg     <= '0;
            track_reg      <= '0;
            sector_reg     <= '0;
            halted_reg     <= 1'b1;
        end
        else if (accept)
        begin
            pos_reg        <= pos_next;
            chain_reg      <= chain_next;
            pair_first_reg <= pair_first_next;
            volume_reg     <= volume_next;
            track_reg      <= track_next;
            sector_reg     <= sector_next;
            halted_reg     <= halted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
        end
        else if (accept)
        begin
            item_reg <= item_next;
        end
        else if (advance)
        begin
            item_reg.valid <= 1'b0;
        end
    end

    assign item = item_reg;

endmodule

`default_nettype wire

@@ design/gcr62_out.sv @@
// ----------------------------------------------------------------------------
// gcr62_out
// Output register: merges the low bit group read back from memory.
// ----------------------------------------------------------------------------
`default_nettype none

module gcr62_out
    import gcr62_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire item_t      item,
    input  wire logic [5:0] rd_data,
    output logic            advance,
    output logic            out_valid,
    input  wire logic       out_ready,
    output status_t         status,
    output logic [7:0]      data_byte,
    output logic [7:0]      byte_index,
    output logic [7:0]      volume_id,
    output logic [7:0]      track_id,
    output logic [7:0]      sector_num,
    output logic            sector_done
);

    logic       valid_reg;
    status_t    status_reg;
    logic [7:0] data_reg, data_next;
    logic [7:0] index_reg, volume_reg, track_reg, sector_reg;
    logic       done_reg;
    logic [1:0] low_bits;

    assign advance = item.valid && (!valid_reg || out_ready);

    always_comb
    begin
        case (item.grp)
            2'd0:    low_bits = rd_data[1:0];
            2'd1:    low_bits = rd_data[3:2];
            default: low_bits = rd_data[5:4];
        endcase
        if (item.status == STATUS_DATA)
        begin
            data_next = {item.upper, swap2(low_bits)};
        end
        else
        begin
            data_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= item.status;
            data_reg   <= data_next;
            index_reg  <= item.index;
            volume_reg <= item.volume;
            track_reg  <= item.track;
            sector_reg <= item.sector;
            done_reg   <= item.done;
        end
    end

    assign out_valid   = valid_reg;
    assign status      = status_reg;
    assign data_byte   = data_reg;
    assign byte_index  = index_reg;
    assign volume_id   = volume_reg;
    assign track_id    = track_reg;
    assign sector_num  = sector_reg;
    assign sector_done = done_reg;

endmodule

`default_nettype wire

@@ design/gcr62_sector_decoder.sv @@
// ----------------------------------------------------------------------------
// gcr62_sector_decoder
// Decoder for one 6-and-2 nibble-encoded sector, header and data field.
// ----------------------------------------------------------------------------
// Feed the raw disk bytes of a sector in order, with tuser high on the first
// byte. The header pairs at positions 10..17 are checked and decoded, the data
// nibbles at 28..369 are looked up and chained, and each of the 256 data bytes
// comes out as one word, the last with tlast. Any error gives one status word
// with tlast and the decoder then drops bytes until the next start mark.
// One byte is accepted every cycle while the output side keeps up; a result
// is held in the front-end item register, loaded in step with the synchronous
// read of the low-group memory, and then in the output register.
`default_nettype none

module gcr62_sector_decoder
    import gcr62_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // disk_byte
    input  wire logic        s_axis_tuser,   // sector_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [39:0] m_axis_tdata,   // data_byte, byte_index, volume_id,
                                             // track_id, sector_num
    output logic      [1:0]  m_axis_tuser,   // status
    output logic             m_axis_tlast    // sector_done
);

    logic                    accept, advance;
    logic                    wr_en, rd_en;
    logic [GROUP_ADDR_W-1:0] wr_addr, rd_addr;
    logic [5:0]              wr_data, rd_data;
    item_t                   item;
    status_t                 status;
    logic [7:0]              data_byte, byte_index, volume_id, track_id, sector_num;

    assign s_axis_tready = !item.valid || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    gcr62_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .advance      (advance),
        .disk_byte    (s_axis_tdata),
        .sector_start (s_axis_tuser),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .item         (item)
    );

    gcr62_group_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gcr62_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .rd_data     (rd_data),
        .advance     (advance),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .status      (status),
        .data_byte   (data_byte),
        .byte_index  (byte_index),
        .volume_id   (volume_id),
        .track_id    (track_id),
        .sector_num  (sector_num),
        .sector_done (m_axis_tlast)
    );

    assign m_axis_tdata = {sector_num, track_id, volume_id, byte_index, data_byte};
    assign m_axis_tuser = status;

endmodule

`default_nettype wire
